// File: hdl/assembler_token_lexer_unit_macros.svh
// Assertion macros for the token lexer.
`ifndef ASSEMBLER_TOKEN_LEXER_UNIT_MACROS_SVH
`define ASSEMBLER_TOKEN_LEXER_UNIT_MACROS_SVH
// implication checked at every clock, off while in reset
`define ATL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, off while in reset
`define ATL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/atl_pkg.sv
// Shared types, constants and helper functions of the token lexer.
package atl_pkg;

  localparam int LOC_BITS = 16;
  localparam logic [LOC_BITS-1:0] LOC_MAX = {LOC_BITS{1'b1}};
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = 2;

  localparam logic [4:0] K_EOF = 5'd0;
  localparam logic [4:0] K_SYM = 5'd16;
  localparam logic [4:0] K_LIT = 5'd23;
  localparam logic [4:0] K_ERR = 5'd24;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_BYTE = 2'd1;
  localparam logic [1:0] E_WORD = 2'd2;
  localparam logic [1:0] E_OVF  = 2'd3;

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_WORD    = 6'b000010,
    M_ZERO    = 6'b000100,
    M_DIGITS  = 6'b001000,
    M_COMMENT = 6'b010000,
    M_HALT    = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    B_DEC = 2'd0,
    B_BIN = 2'd1,
    B_HEX = 2'd2
  } base_t;

  typedef struct packed {
    logic [4:0]          kind;
    logic [63:0]         value;
    logic [LOC_BITS-1:0] line;
    logic [LOC_BITS-1:0] column;
    logic [1:0]          err;
  } tok_t;

  // one queue entry: the tokens that one input word causes
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } rec_t;

  function automatic logic [LOC_BITS-1:0] sat_add(input logic [LOC_BITS-1:0] v,
                                                  input logic [3:0] d);
    logic [LOC_BITS:0] s;
    s = {1'b0, v} + {{(LOC_BITS-3){1'b0}}, d};
    return s[LOC_BITS] ? LOC_MAX : s[LOC_BITS-1:0];
  endfunction

  // keyword number 1..15, 0 when no keyword matches
  function automatic logic [4:0] kw_kind(input logic [2:0] len, input logic [23:0] w);
    logic [4:0] k;
    k = 5'd0;
    if (len == 3'd3) begin
      unique case (w)
        "add":   k = 5'd1;
        "dec":   k = 5'd2;
        "div":   k = 5'd3;
        "inc":   k = 5'd4;
        "mov":   k = 5'd5;
        "mul":   k = 5'd6;
        "sub":   k = 5'd15;
        default: k = 5'd0;
      endcase
    end else if (len == 3'd2) begin
      unique case (w)
        {8'h00, "pc"}: k = 5'd7;
        {8'h00, "ra"}: k = 5'd8;
        {8'h00, "rb"}: k = 5'd9;
        {8'h00, "rc"}: k = 5'd10;
        {8'h00, "rx"}: k = 5'd11;
        {8'h00, "ry"}: k = 5'd12;
        {8'h00, "rz"}: k = 5'd13;
        {8'h00, "sp"}: k = 5'd14;
        default:       k = 5'd0;
      endcase
    end
    return k;
  endfunction

endpackage

// File: hdl/atl_front.sv
// Front end: scans each source byte and builds the tokens it causes.
module atl_front import atl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  ch,
  input  logic        is_end,
  output logic        push,
  output rec_t        rec
);

  mode_t               mode_r, mode_nxt;
  logic [23:0]         word_r, word_nxt;
  logic [2:0]          wlen_r, wlen_nxt;
  logic [63:0]         acc_r, acc_nxt;
  base_t               base_r, base_nxt;
  logic                ovf_r, ovf_nxt;
  logic [LOC_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [LOC_BITS-1:0] sline_r, sline_nxt, scol_r, scol_nxt;

  // byte classes
  logic       c_ws, c_dig, c_alpha, c_word, c_semi, c_sym;
  logic [7:0] c_low;
  logic [2:0] sym_idx;
  logic [4:0] dval;
  logic       dok;
  logic [67:0] prod;

  // idle handling of the byte
  mode_t ib_mode;
  logic  ib_emit;
  tok_t  ib_tok;

  // finishing a pending word or literal
  logic  fin_emit, fin_halt;
  tok_t  fin_tok;
  logic  sec_emit;
  tok_t  sec_tok;
  logic  do_idle;
  logic [4:0] kw;

  always_comb begin
    c_ws    = (ch == 8'h09) || (ch == 8'h0A) || (ch == 8'h20);
    c_dig   = (ch >= "0") && (ch <= "9");
    c_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    c_word  = c_alpha || (ch == "_");
    c_semi  = (ch == ";");
    c_low   = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
    c_sym   = 1'b1;
    unique case (ch)
      "(":     sym_idx = 3'd0;
      ")":     sym_idx = 3'd1;
      ",":     sym_idx = 3'd2;
      "$":     sym_idx = 3'd3;
      ":":     sym_idx = 3'd4;
      "+":     sym_idx = 3'd5;
      "-":     sym_idx = 3'd6;
      default: begin
        sym_idx = 3'd0;
        c_sym   = 1'b0;
      end
    endcase
    // digit value in the current base
    if (c_dig) begin
      dval = {1'b0, ch[3:0]};
    end else if ((ch >= "a") && (ch <= "f")) begin
      dval = {1'b0, ch[3:0]} + 5'd9;
    end else if ((ch >= "A") && (ch <= "F")) begin
      dval = {1'b0, ch[3:0]} + 5'd9;
    end else begin
      dval = 5'd16;
    end
    unique case (base_r)
      B_BIN:   dok = dval < 5'd2;
      B_HEX:   dok = dval < 5'd16;
      default: dok = dval < 5'd10;
    endcase
    // acc * radix + digit by shifts; top bits flag overflow
    unique case (base_r)
      B_BIN:   prod = {3'b0, acc_r, 1'b0};
      B_HEX:   prod = {acc_r, 4'b0};
      default: prod = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0};
    endcase
    prod = prod + {64'd0, dval[3:0]};
  end

  // location counters after this word
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (!is_end && (ch == 8'h0A)) begin
      line_nxt = sat_add(line_r, 4'd1);
      col_nxt  = '0;
    end else begin
      col_nxt = sat_add(col_r, (!is_end && (ch == 8'h09)) ? 4'd8 : 4'd1);
    end
  end

  always_comb begin
    ib_tok        = '0;
    ib_tok.line   = line_nxt;
    ib_tok.column = col_nxt;
    ib_emit       = 1'b0;
    ib_mode       = M_IDLE;
    priority if (c_ws) begin
      ib_mode = M_IDLE;
    end else if (c_dig) begin
      ib_mode = (ch == "0") ? M_ZERO : M_DIGITS;
    end else if (c_word) begin
      ib_mode = M_WORD;
    end else if (c_semi) begin
      ib_mode = M_COMMENT;
    end else if (c_sym) begin
      ib_emit     = 1'b1;
      ib_tok.kind = K_SYM + {2'b0, sym_idx};
    end else begin
      ib_emit     = 1'b1;
      ib_tok.kind = K_ERR;
      ib_tok.err  = E_BYTE;
      ib_mode     = M_HALT;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    word_nxt  = word_r;
    wlen_nxt  = wlen_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    ovf_nxt   = ovf_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    fin_emit  = 1'b0;
    fin_halt  = 1'b0;
    fin_tok   = '0;
    fin_tok.line   = sline_r;
    fin_tok.column = scol_r;
    sec_emit  = 1'b0;
    sec_tok   = ib_tok;
    do_idle   = 1'b0;
    kw        = kw_kind(wlen_r, word_r);

    // a word or literal in progress, closed by this byte or by the end
    if (mode_r == M_WORD) begin
      if (kw != 5'd0) begin
        fin_tok.kind = kw;
      end else begin
        fin_tok.kind = K_ERR;
        fin_tok.err  = E_WORD;
        fin_halt     = 1'b1;
      end
    end else if (ovf_r) begin
      fin_tok.kind = K_ERR;
      fin_tok.err  = E_OVF;
      fin_halt     = 1'b1;
    end else begin
      fin_tok.kind  = K_LIT;
      fin_tok.value = acc_r;
    end

    if (mode_r == M_HALT) begin
      mode_nxt = M_HALT;
    end else if (is_end) begin
      fin_emit = (mode_r == M_WORD) || (mode_r == M_ZERO) || (mode_r == M_DIGITS);
      if (fin_emit && fin_halt) begin
        mode_nxt = M_HALT;
      end else begin
        mode_nxt       = M_IDLE;
        sline_nxt      = line_nxt;
        scol_nxt       = col_nxt;
        sec_emit       = 1'b1;
        sec_tok        = '0;
        sec_tok.kind   = K_EOF;
        sec_tok.line   = line_nxt;
        sec_tok.column = col_nxt;
      end
    end else begin
      unique case (mode_r)
        M_COMMENT: begin
          if (ch == 8'h0A) mode_nxt = M_IDLE;
        end
        M_WORD: begin
          if (c_word) begin
            if (wlen_r < 3'd3) begin
              word_nxt = {word_r[15:0], c_low};
              wlen_nxt = wlen_r + 3'd1;
            end else begin
              wlen_nxt = 3'd4;
            end
          end else begin
            fin_emit = 1'b1;
            if (fin_halt) mode_nxt = M_HALT;
            else do_idle = 1'b1;
          end
        end
        M_ZERO, M_DIGITS: begin
          if ((mode_r == M_ZERO) && ((ch == "b") || (ch == "x"))) begin
            base_nxt = (ch == "b") ? B_BIN : B_HEX;
            mode_nxt = M_DIGITS;
          end else if (dok) begin
            mode_nxt = M_DIGITS;
            if (!ovf_r) begin
              if (prod[67:64] != 4'd0) ovf_nxt = 1'b1;
              else acc_nxt = prod[63:0];
            end
          end else begin
            fin_emit = 1'b1;
            if (fin_halt) mode_nxt = M_HALT;
            else do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_nxt = ib_mode;
        sec_emit = ib_emit;
        if (!c_ws) begin
          sline_nxt = line_nxt;
          scol_nxt  = col_nxt;
        end
        if (c_dig) begin
          acc_nxt  = {60'd0, ch[3:0]};
          base_nxt = B_DEC;
          ovf_nxt  = 1'b0;
        end
        if (c_word && !c_dig) begin
          word_nxt = {16'd0, c_low};
          wlen_nxt = 3'd1;
        end
      end
    end

    rec = '0;
    if (fin_emit) begin
      rec.tok0 = fin_tok;
      rec.tok1 = sec_tok;
      rec.cnt  = sec_emit ? 2'd2 : 2'd1;
    end else begin
      rec.tok0 = sec_tok;
      rec.cnt  = sec_emit ? 2'd1 : 2'd0;
    end
  end

  assign push = fire && (rec.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      word_r  <= '0;
      wlen_r  <= '0;
      acc_r   <= '0;
      base_r  <= B_DEC;
      ovf_r   <= 1'b0;
      line_r  <= {{(LOC_BITS-1){1'b0}}, 1'b1};
      col_r   <= {{(LOC_BITS-1){1'b0}}, 1'b1};
      sline_r <= '0;
      scol_r  <= '0;
    end else if (fire && (mode_r != M_HALT)) begin
      mode_r  <= mode_nxt;
      word_r  <= word_nxt;
      wlen_r  <= wlen_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      ovf_r   <= ovf_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
    end
  end

endmodule

// File: hdl/atl_queue.sv
// Short FIFO of token records between front and back end.
module atl_queue import atl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rec_t                 wr_rec,
  input  logic                 pop,
  output rec_t                 rd_rec,
  output logic                 empty,
  output logic                 full,
  output logic [QPTR_BITS:0]   count
);

  rec_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == QDEPTH[QPTR_BITS:0]);
  assign count  = cnt_r;
  assign rd_rec = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/atl_back.sv
// Back end: unpacks token records into single output words.
module atl_back import atl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  rec_t                head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tok_t                out_tok,
  output logic                out_last
);

  logic sub_r, sub_nxt;
  logic valid_r, valid_nxt;
  tok_t tok_r;
  logic last_r;
  logic load, at_last;

  assign load    = !empty && (!valid_r || out_ready);
  assign at_last = (head.cnt == 2'd1) || sub_r;
  assign pop     = load && at_last;

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = !at_last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sub_r ? head.tok1 : head.tok0;
      last_r <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

// File: hdl/assembler_token_lexer_unit.sv
// Top level of the assembler token lexer.
// Input channel in_*: one source byte per word (in_ch), or an end-of-source
//   marker (in_is_end). Output channel out_*: one token per word, out_last
//   set on the final token caused by an input word (at most two per word).
// Throughput: one input word per cycle while the queue is not full; a byte
//   that closes a literal or word and also yields a token gives two output
//   words through the single output register of the back end.
// An accepted byte's first token reaches out_* by a queue write at the
//   accepting edge, then an output register load.
// The front end scans bytes and writes token records into a 4-deep queue;
//   the back end drains it, so either side can stall on its own. in_ready
//   drops only while the queue is full.
// Receiver stall: the output word holds; the queue fills, then input stalls.
// Reset (rst_n, synchronous): lexer idle at line 1 column 1, queue empty,
//   output invalid, file number 0. After an error token the lexer halts:
//   it still takes input words but gives nothing until reset.
// cfg_we/cfg_wdata load the file number register at once.
`include "assembler_token_lexer_unit_macros.svh"
module assembler_token_lexer_unit import atl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                in_is_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          out_token_kind,
  output logic [63:0]         out_literal_value,
  output logic [LOC_BITS-1:0] out_token_line,
  output logic [LOC_BITS-1:0] out_token_column,
  output logic [1:0]          out_error_code,
  output logic                out_last
);

  logic [7:0] file_id_r;   // file number register; no output carries it

  logic                 fire, push, pop, q_empty, q_full;
  logic [QPTR_BITS:0]   q_count;
  rec_t                 wr_rec, head;
  tok_t                 tok;

  always_ff @(posedge clk) begin
    if (!rst_n) file_id_r <= '0;
    else if (cfg_we) file_id_r <= cfg_wdata;
  end

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  atl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .ch     (in_ch),
    .is_end (in_is_end),
    .push   (push),
    .rec    (wr_rec)
  );

  atl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (head),
    .empty  (q_empty),
    .full   (q_full),
    .count  (q_count)
  );

  atl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (tok),
    .out_last  (out_last)
  );

  assign out_token_kind    = tok.kind;
  assign out_literal_value = tok.value;
  assign out_token_line    = tok.line;
  assign out_token_column  = tok.column;
  assign out_error_code    = tok.err;

  `ATL_ASSERT_IMP(a_ready_room, (q_count != QDEPTH[QPTR_BITS:0]), in_ready, "ready low with room")
  `ATL_ASSERT_IMP(a_err_code, out_valid, ((out_token_kind == K_ERR) == (out_error_code != E_NONE)), "error code mismatch")
  `ATL_ASSERT_IMP(a_lit_value, (out_valid && (out_token_kind != K_LIT)), (out_literal_value == 64'd0), "value on non-literal")
  `ATL_ASSERT_NXT(a_pop_space, (q_full && !pop), q_count == QDEPTH[QPTR_BITS:0], "queue lost entry")

endmodule
